// ===== rtl/fswe_pkg.sv =====
`default_nettype none
package fswe_pkg;

    localparam int ADDR_W     = 32;
    localparam int COUNT_W    = 19;
    localparam int PAGES_W    = 6;
    localparam int WORD_BYTES = 16;
    localparam int WORD_W     = WORD_BYTES * 8;
    localparam int PAGE_SHIFT = 13;
    localparam int MAX_PAGES  = 60;
    localparam int BUDGET_W   = $clog2(MAX_PAGES + 1);

    localparam logic [ADDR_W-1:0] PAGE_BYTES = ADDR_W'(1) << PAGE_SHIFT;
    localparam logic [ADDR_W-1:0] PAGE_MASK  = ~(PAGE_BYTES - ADDR_W'(1));
    localparam logic [ADDR_W-1:0] WORD_STEP  = ADDR_W'(WORD_BYTES);

    localparam logic [ADDR_W-1:0]  BASE_RESET    = 32'h0810_0000;
    localparam logic [PAGES_W-1:0] PAGES_RESET   = PAGES_W'(MAX_PAGES);
    localparam logic [7:0]         TRIGGER_RESET = 8'h70;
    localparam logic [7:0]         ERASED_BYTE   = 8'hFF;

    localparam logic [1:0] CFG_PARTITION_BASE  = 2'd0;
    localparam logic [1:0] CFG_PARTITION_PAGES = 2'd1;
    localparam logic [1:0] CFG_TRIGGER_VALUE   = 2'd2;

    localparam logic [1:0] KIND_OPEN   = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;

    localparam logic [1:0] CMD_ERASE   = 2'd0;
    localparam logic [1:0] CMD_PROGRAM = 2'd1;
    localparam logic [1:0] CMD_STATUS  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERSIZE = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic        chunk_start;
        logic [15:0] chunk_len;
        logic [31:0] announced_size;
    } t_item;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] flash_address;
        logic [63:0] word_low;
        logic [63:0] word_high;
        logic [1:0]  status;
        logic [18:0] byte_count;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [ADDR_W-1:0]  base;
        logic [PAGES_W-1:0] pages;
        logic [7:0]         trigger;
    } t_cfg;

    typedef enum logic [1:0] {
        OP_OPEN,
        OP_ERR,
        OP_WORD,
        OP_FINISH
    } t_op_kind;

    typedef struct packed {
        t_op_kind           kind;
        logic [WORD_W-1:0]  word;
        logic               has_word;
        logic               mismatch;
        logic [COUNT_W-1:0] byte_count;
    } t_op;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_ERASE_WORD,
        BK_PROGRAM,
        BK_FINISH,
        BK_ERASE_TAIL,
        BK_TRIGGER,
        BK_STATUS
    } t_back_state;

    function automatic logic [PAGES_W-1:0] eff_pages(input logic [PAGES_W-1:0] pages);
        logic [PAGES_W-1:0] res;
        res = (pages > PAGES_W'(MAX_PAGES)) ? PAGES_W'(MAX_PAGES) : pages;
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/fswe_front.sv =====
`default_nettype none
module fswe_front (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    input  wire logic                   i_full,
    input  wire fswe_pkg::t_item        i_item,
    input  wire fswe_pkg::t_cfg         i_cfg,
    output logic                        o_op_push,
    output fswe_pkg::t_op               o_op
);

    localparam int CW = fswe_pkg::COUNT_W;

    logic [CW-1:0] r_count, n_count;
    logic [3:0]    r_fill, n_fill;
    logic          r_drop, n_drop;
    logic [7:0]    r_buf [16];

    logic              w_accept;
    logic              w_take;
    logic [CW-1:0]     w_limit;
    logic [CW:0]       w_sum;
    logic              w_over;
    logic              w_drop;
    logic [fswe_pkg::WORD_W-1:0] w_word_new;
    logic [fswe_pkg::WORD_W-1:0] w_word_pad;

    assign w_accept = i_push && !i_full;
    assign w_limit  = CW'(fswe_pkg::eff_pages(i_cfg.pages)) << fswe_pkg::PAGE_SHIFT;
    assign w_sum    = {1'b0, r_count} + (CW + 1)'(i_item.chunk_len);
    assign w_over   = w_sum > {1'b0, w_limit};
    assign w_drop   = i_item.chunk_start ? w_over : r_drop;
    assign w_take   = !w_drop && (r_count < w_limit);

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            if (4'(i) < r_fill) begin
                w_word_new[i*8 +: 8] = r_buf[i];
                w_word_pad[i*8 +: 8] = r_buf[i];
            end else if (4'(i) == r_fill) begin
                w_word_new[i*8 +: 8] = i_item.data_byte;
                w_word_pad[i*8 +: 8] = fswe_pkg::ERASED_BYTE;
            end else begin
                w_word_new[i*8 +: 8] = fswe_pkg::ERASED_BYTE;
                w_word_pad[i*8 +: 8] = fswe_pkg::ERASED_BYTE;
            end
        end
    end

    always_comb begin
        n_count         = r_count;
        n_fill          = r_fill;
        n_drop          = r_drop;
        o_op_push       = 1'b0;
        o_op.kind       = fswe_pkg::OP_OPEN;
        o_op.word       = w_word_new;
        o_op.has_word   = 1'b0;
        o_op.mismatch   = 1'b0;
        o_op.byte_count = r_count;
        if (w_accept) begin
            case (i_item.kind)
                fswe_pkg::KIND_OPEN: begin
                    n_count   = '0;
                    n_fill    = '0;
                    n_drop    = 1'b0;
                    o_op_push = 1'b1;
                end
                fswe_pkg::KIND_DATA: begin
                    n_drop = w_drop;
                    if (i_item.chunk_start && w_over) begin
                        o_op_push = 1'b1;
                        o_op.kind = fswe_pkg::OP_ERR;
                    end
                    if (w_take) begin
                        n_count = r_count + CW'(1);
                        n_fill  = r_fill + 4'd1;
                        if (r_fill == 4'd15) begin
                            o_op_push       = 1'b1;
                            o_op.kind       = fswe_pkg::OP_WORD;
                            o_op.byte_count = n_count;
                        end
                    end
                end
                fswe_pkg::KIND_FINISH: begin
                    o_op_push     = 1'b1;
                    o_op.kind     = fswe_pkg::OP_FINISH;
                    o_op.word     = w_word_pad;
                    o_op.has_word = r_fill != 4'd0;
                    o_op.mismatch = (i_item.announced_size != 32'd0)
                                    && (i_item.announced_size != 32'(r_count));
                    n_fill        = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_fill  <= '0;
            r_drop  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_fill  <= n_fill;
            r_drop  <= n_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (i_item.kind == fswe_pkg::KIND_DATA) && w_take) begin
            r_buf[r_fill] <= i_item.data_byte;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/fswe_queue.sv =====
`default_nettype none
module fswe_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire fswe_pkg::t_op i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_empty,
    output fswe_pkg::t_op      o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    fswe_pkg::t_op   r_mem [DEPTH];
    logic [PW-1:0]   r_wr, n_wr;
    logic [PW-1:0]   r_rd, n_rd;
    logic [NW-1:0]   r_cnt, n_cnt;
    logic            w_push;
    logic            w_pop;

    assign o_full  = r_cnt == NW'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (w_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        case ({w_push, w_pop})
            2'b10:   n_cnt = r_cnt + NW'(1);
            2'b01:   n_cnt = r_cnt - NW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/fswe_back.sv =====
`default_nettype none
module fswe_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire fswe_pkg::t_cfg    i_cfg,
    input  wire logic              i_q_empty,
    input  wire fswe_pkg::t_op     i_q_data,
    output logic                   o_q_pop,
    output logic                   o_empty,
    input  wire logic              i_pop,
    output fswe_pkg::t_result      o_result
);

    localparam int AW = fswe_pkg::ADDR_W;

    fswe_pkg::t_back_state r_state, n_state;
    fswe_pkg::t_op         r_op, n_op;
    fswe_pkg::t_result     r_out, n_out;
    logic                  r_out_valid, n_out_valid;
    logic [AW-1:0]         r_erased, n_erased;
    logic [AW-1:0]         r_waddr, n_waddr;
    logic [AW-1:0]         r_trailer, n_trailer;
    logic [fswe_pkg::BUDGET_W-1:0] r_budget, n_budget;

    logic                  w_free;
    logic [AW-1:0]         w_end;
    logic                  w_need_erase;
    logic [AW-1:0]         w_size;
    logic [fswe_pkg::WORD_W-1:0] w_trig_word;

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;
    assign w_free   = !r_out_valid || i_pop;
    assign w_size   = AW'(fswe_pkg::eff_pages(i_cfg.pages)) << fswe_pkg::PAGE_SHIFT;
    assign w_end    = (r_state == fswe_pkg::BK_ERASE_WORD)
                      ? r_waddr + fswe_pkg::WORD_STEP
                      : (r_trailer & fswe_pkg::PAGE_MASK) + fswe_pkg::PAGE_BYTES;
    assign w_need_erase = (r_erased < w_end) && (r_budget != '0);

    always_comb begin
        for (int i = 0; i < fswe_pkg::WORD_BYTES; i++) begin
            w_trig_word[i*8 +: 8] = (r_trailer[3:0] == 4'(i))
                                    ? i_cfg.trigger : fswe_pkg::ERASED_BYTE;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_pop;
        n_erased    = r_erased;
        n_waddr     = r_waddr;
        n_trailer   = r_trailer;
        n_budget    = r_budget;
        o_q_pop     = 1'b0;

        n_out.command       = fswe_pkg::CMD_ERASE;
        n_out.flash_address = r_erased;
        n_out.word_low      = '0;
        n_out.word_high     = '0;
        n_out.status        = fswe_pkg::ST_OK;
        n_out.byte_count    = r_op.byte_count;
        n_out.last          = 1'b0;
        if (!w_free) begin
            n_out = r_out;
        end

        case (r_state)
            fswe_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop  = 1'b1;
                    n_op     = i_q_data;
                    n_budget = fswe_pkg::BUDGET_W'(fswe_pkg::MAX_PAGES);
                    case (i_q_data.kind)
                        fswe_pkg::OP_OPEN: begin
                            n_erased = i_cfg.base;
                            n_waddr  = i_cfg.base;
                        end
                        fswe_pkg::OP_ERR:  n_state = fswe_pkg::BK_STATUS;
                        fswe_pkg::OP_WORD: n_state = fswe_pkg::BK_ERASE_WORD;
                        fswe_pkg::OP_FINISH: begin
                            n_state = i_q_data.has_word ? fswe_pkg::BK_ERASE_WORD
                                                        : fswe_pkg::BK_FINISH;
                        end
                        default: n_state = fswe_pkg::BK_IDLE;
                    endcase
                end
            end
            fswe_pkg::BK_ERASE_WORD, fswe_pkg::BK_ERASE_TAIL: begin
                if (w_need_erase) begin
                    if (w_free) begin
                        n_out_valid = 1'b1;
                        n_erased    = r_erased + fswe_pkg::PAGE_BYTES;
                        n_budget    = r_budget - fswe_pkg::BUDGET_W'(1);
                    end
                end else begin
                    n_state = (r_state == fswe_pkg::BK_ERASE_WORD)
                              ? fswe_pkg::BK_PROGRAM : fswe_pkg::BK_TRIGGER;
                end
            end
            fswe_pkg::BK_PROGRAM: begin
                if (w_free) begin
                    n_out_valid         = 1'b1;
                    n_out.command       = fswe_pkg::CMD_PROGRAM;
                    n_out.flash_address = r_waddr;
                    n_out.word_low      = r_op.word[63:0];
                    n_out.word_high     = r_op.word[127:64];
                    n_out.last          = r_op.kind == fswe_pkg::OP_WORD;
                    n_waddr             = r_waddr + fswe_pkg::WORD_STEP;
                    n_state = (r_op.kind == fswe_pkg::OP_WORD)
                              ? fswe_pkg::BK_IDLE : fswe_pkg::BK_FINISH;
                end
            end
            fswe_pkg::BK_FINISH: begin
                if (r_op.mismatch) begin
                    n_state = fswe_pkg::BK_STATUS;
                end else begin
                    n_trailer = i_cfg.base + w_size - AW'(1);
                    n_state   = fswe_pkg::BK_ERASE_TAIL;
                end
            end
            fswe_pkg::BK_TRIGGER: begin
                if (w_free) begin
                    n_out_valid         = 1'b1;
                    n_out.command       = fswe_pkg::CMD_PROGRAM;
                    n_out.flash_address = {r_trailer[AW-1:4], 4'd0};
                    n_out.word_low      = w_trig_word[63:0];
                    n_out.word_high     = w_trig_word[127:64];
                    n_out.last          = 1'b1;
                    n_state             = fswe_pkg::BK_IDLE;
                end
            end
            fswe_pkg::BK_STATUS: begin
                if (w_free) begin
                    n_out_valid         = 1'b1;
                    n_out.command       = fswe_pkg::CMD_STATUS;
                    n_out.flash_address = '0;
                    n_out.status        = (r_op.kind == fswe_pkg::OP_ERR)
                                          ? fswe_pkg::ST_OVERSIZE : fswe_pkg::ST_MISMATCH;
                    n_out.last          = 1'b1;
                    n_state             = fswe_pkg::BK_IDLE;
                end
            end
            default: n_state = fswe_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fswe_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
            r_erased    <= fswe_pkg::BASE_RESET;
            r_waddr     <= fswe_pkg::BASE_RESET;
            r_budget    <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_erased    <= n_erased;
            r_waddr     <= n_waddr;
            r_budget    <= n_budget;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_out     <= n_out;
        r_trailer <= n_trailer;
    end

endmodule
`default_nettype wire

// ===== rtl/flash_stage_writer_erase_on_demand.sv =====
// Stages a byte stream into a flash partition as 16-byte quad-word programs,
// erasing each page on demand just before the first program that reaches it.
// Items go in through a queue-style push/full port and results come out
// through an empty/pop port, one result per flash command or status report.
// The front end takes one item per cycle as long as the op queue between
// front and back has room; only open, chunk errors, completed quad-words and
// finish put an op in that queue. The back end pops an op only while idle and
// finishes it before the next: a quad-word gets an erase for each page it
// reaches first, then its program; a finish may erase the rest of the
// partition and program the trigger byte. One op erases at most 60 pages.
// The user must write partition base, page count and trigger byte through
// the configuration port only while the block is idle; the block does not
// enforce it. A page count above 60 acts as 60 and 0 makes every byte drop.
`default_nettype none
module flash_stage_writer_erase_on_demand #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire fswe_pkg::t_item    i_item,
    output logic                    empty,
    input  wire logic               pop,
    output fswe_pkg::t_result       o_result,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);

    fswe_pkg::t_cfg r_cfg;
    fswe_pkg::t_op  w_op_in;
    fswe_pkg::t_op  w_op_out;
    logic           w_op_push;
    logic           w_q_empty;
    logic           w_q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base    <= fswe_pkg::BASE_RESET;
            r_cfg.pages   <= fswe_pkg::PAGES_RESET;
            r_cfg.trigger <= fswe_pkg::TRIGGER_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fswe_pkg::CFG_PARTITION_BASE:  r_cfg.base    <= i_cfg_data;
                fswe_pkg::CFG_PARTITION_PAGES: r_cfg.pages   <= i_cfg_data[fswe_pkg::PAGES_W-1:0];
                fswe_pkg::CFG_TRIGGER_VALUE:   r_cfg.trigger <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    fswe_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_full    (full),
        .i_item    (i_item),
        .i_cfg     (r_cfg),
        .o_op_push (w_op_push),
        .o_op      (w_op_in)
    );

    fswe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_op_push),
        .i_data  (w_op_in),
        .o_full  (full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_data  (w_op_out)
    );

    fswe_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (w_q_empty),
        .i_q_data  (w_op_out),
        .o_q_pop   (w_q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_result  (o_result)
    );

endmodule
`default_nettype wire

// ===== rtl/fswe_checker.sv =====
`default_nettype none
module fswe_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              push,
    input wire logic              full,
    input wire logic              empty,
    input wire logic              pop,
    input wire fswe_pkg::t_result o_result
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queue ports not cleared after reset");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_result))
        else $error("waiting result changed or vanished");

    a_erase_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_result.command == fswe_pkg::CMD_ERASE)
        |-> !o_result.last && (o_result.word_low == '0) && (o_result.word_high == '0))
        else $error("erase result marked last or carries data");

    a_status_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_result.command == fswe_pkg::CMD_STATUS)
        |-> o_result.last && (o_result.flash_address == '0)
            && (o_result.status != fswe_pkg::ST_OK))
        else $error("malformed status report");

    a_ok_on_flash_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_result.command != fswe_pkg::CMD_STATUS)
        |-> o_result.status == fswe_pkg::ST_OK)
        else $error("flash command with error status");

endmodule

bind flash_stage_writer_erase_on_demand fswe_checker u_fswe_checker (.*);
`default_nettype wire
